FILE: rtl/character_range_expander_unit_defines.svh
// Assertion macros used by the character range expander datapath.
`ifndef CHARACTER_RANGE_EXPANDER_UNIT_DEFINES_SVH
`define CHARACTER_RANGE_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CRX_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crx assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CRX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crx assertion failed");

`endif

FILE: rtl/crx_pkg.sv
package crx_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_DASH    = 8'h2D;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_UPPER = 2'd1,
        CLASS_LOWER = 2'd2,
        CLASS_DIGIT = 2'd3
    } class_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_FETCH      = 3'd0;
    localparam upc_t UPC_TEST_FULL  = 3'd1;
    localparam upc_t UPC_TEST_RANGE = 3'd2;
    localparam upc_t UPC_RANGE      = 3'd3;
    localparam upc_t UPC_LITERAL    = 3'd4;
    localparam upc_t UPC_INSERT     = 3'd5;
    localparam upc_t UPC_FLUSH      = 3'd6;

    typedef enum logic [2:0] {
        COND_IN_VALID   = 3'd0,
        COND_WIN_FULL   = 3'd1,
        COND_RANGE      = 3'd2,
        COND_RUN_DONE   = 3'd3,
        COND_LAST       = 3'd4,
        COND_FLUSH_DONE = 3'd5
    } cond_t;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_LOAD       = 3'd1,
        OP_SET_CNT    = 3'd2,
        OP_RANGE_STEP = 3'd3,
        OP_SHIFT_IN   = 3'd4,
        OP_INSERT     = 3'd5,
        OP_SHIFT_OUT  = 3'd6
    } op_t;

    typedef enum logic {
        SRC_CNT = 1'b0,
        SRC_W0  = 1'b1
    } src_t;

    typedef enum logic {
        RL_COND  = 1'b0,
        RL_NCOND = 1'b1
    } rl_t;

    typedef struct packed {
        cond_t cond;
        logic  wait_cond;
        op_t   op;
        logic  emit;
        src_t  src;
        rl_t   rl;
        upc_t  jump_true;
        upc_t  jump_false;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic fire;
        logic emit;
        src_t src;
        logic run_last;
    } ctrl_t;

    typedef struct packed {
        logic win_full;
        logic is_range;
        logic run_done;
        logic last;
        logic flush_done;
        logic out_free;
    } status_t;

    function automatic class_t byte_class(logic [7:0] b);
        class_t cls;
        cls = CLASS_NONE;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
        begin
            cls = CLASS_UPPER;
        end
        else if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
        begin
            cls = CLASS_LOWER;
        end
        else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9)
        begin
            cls = CLASS_DIGIT;
        end
        return cls;
    endfunction

    function automatic ucode_t ucode_rom(upc_t pc);
        ucode_t cw;
        cw = '{cond: COND_IN_VALID, wait_cond: 1'b0, op: OP_NONE, emit: 1'b0,
               src: SRC_W0, rl: RL_COND, jump_true: UPC_FETCH, jump_false: UPC_FETCH};
        case (pc)
            UPC_FETCH:
            begin
                cw.cond       = COND_IN_VALID;
                cw.wait_cond  = 1'b1;
                cw.op         = OP_LOAD;
                cw.jump_true  = UPC_TEST_FULL;
                cw.jump_false = UPC_FETCH;
            end
            UPC_TEST_FULL:
            begin
                cw.cond       = COND_WIN_FULL;
                cw.jump_true  = UPC_TEST_RANGE;
                cw.jump_false = UPC_INSERT;
            end
            UPC_TEST_RANGE:
            begin
                cw.cond       = COND_RANGE;
                cw.op         = OP_SET_CNT;
                cw.jump_true  = UPC_RANGE;
                cw.jump_false = UPC_LITERAL;
            end
            UPC_RANGE:
            begin
                cw.cond       = COND_RUN_DONE;
                cw.op         = OP_RANGE_STEP;
                cw.emit       = 1'b1;
                cw.src        = SRC_CNT;
                cw.rl         = RL_COND;
                cw.jump_true  = UPC_FETCH;
                cw.jump_false = UPC_RANGE;
            end
            UPC_LITERAL:
            begin
                cw.cond       = COND_LAST;
                cw.op         = OP_SHIFT_IN;
                cw.emit       = 1'b1;
                cw.src        = SRC_W0;
                cw.rl         = RL_NCOND;
                cw.jump_true  = UPC_FLUSH;
                cw.jump_false = UPC_FETCH;
            end
            UPC_INSERT:
            begin
                cw.cond       = COND_LAST;
                cw.op         = OP_INSERT;
                cw.jump_true  = UPC_FLUSH;
                cw.jump_false = UPC_FETCH;
            end
            UPC_FLUSH:
            begin
                cw.cond       = COND_FLUSH_DONE;
                cw.op         = OP_SHIFT_OUT;
                cw.emit       = 1'b1;
                cw.src        = SRC_W0;
                cw.rl         = RL_COND;
                cw.jump_true  = UPC_FETCH;
                cw.jump_false = UPC_FLUSH;
            end
            default:
            begin
                cw.jump_true  = UPC_FETCH;
                cw.jump_false = UPC_FETCH;
            end
        endcase
        return cw;
    endfunction

endpackage

FILE: rtl/crx_sequencer.sv
module crx_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  crx_pkg::status_t  status,
    output crx_pkg::ctrl_t    ctrl
);

    crx_pkg::upc_t   pc_reg;
    crx_pkg::upc_t   pc_next;
    crx_pkg::ucode_t cw;
    logic            cond_val;
    logic            fire;

    always_comb
    begin
        cw = crx_pkg::ucode_rom(pc_reg);
        case (cw.cond)
            crx_pkg::COND_IN_VALID:   cond_val = in_valid;
            crx_pkg::COND_WIN_FULL:   cond_val = status.win_full;
            crx_pkg::COND_RANGE:      cond_val = status.is_range;
            crx_pkg::COND_RUN_DONE:   cond_val = status.run_done;
            crx_pkg::COND_LAST:       cond_val = status.last;
            crx_pkg::COND_FLUSH_DONE: cond_val = status.flush_done;
            default:                  cond_val = 1'b0;
        endcase
        // An emitting step holds until the output register can take a beat.
        fire = (!cw.emit || status.out_free) && (!cw.wait_cond || cond_val);
        if (fire)
        begin
            pc_next = cond_val ? cw.jump_true : cw.jump_false;
        end
        else
        begin
            pc_next = pc_reg;
        end
        ctrl.op       = cw.op;
        ctrl.fire     = fire;
        ctrl.emit     = cw.emit;
        ctrl.src      = cw.src;
        ctrl.run_last = (cw.rl == crx_pkg::RL_COND) ? cond_val : !cond_val;
    end

    assign in_stall = (pc_reg != crx_pkg::UPC_FETCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= crx_pkg::UPC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: rtl/crx_datapath.sv
`include "character_range_expander_unit_defines.svh"

module crx_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    input  crx_pkg::ctrl_t    ctrl,
    output crx_pkg::status_t  status,
    output logic [7:0]        out_char,
    output logic              run_last,
    output logic              text_end,
    output logic              out_valid,
    input  logic              out_stall
);

    logic [7:0] w0_reg;
    logic [7:0] w0_next;
    logic [7:0] w1_reg;
    logic [7:0] w1_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic [7:0] c_reg;
    logic [7:0] c_next;
    logic       last_reg;
    logic       last_next;
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       run_last_reg;
    logic       run_last_next;
    logic       text_end_reg;
    logic       text_end_next;
    logic       emit_beat;

    crx_pkg::class_t w0_class;

    always_comb
    begin
        w0_class          = crx_pkg::byte_class(w0_reg);
        status.win_full   = (fill_reg == 2'd2);
        status.is_range   = (w0_class != crx_pkg::CLASS_NONE) && (w1_reg == crx_pkg::CH_DASH)
                            && (crx_pkg::byte_class(c_reg) == w0_class) && (c_reg >= w0_reg);
        status.run_done   = (cnt_reg == c_reg);
        status.last       = last_reg;
        status.flush_done = (fill_reg == 2'd1);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        fill_next = fill_reg;
        c_next    = c_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (ctrl.fire)
        begin
            case (ctrl.op)
                crx_pkg::OP_LOAD:
                begin
                    c_next    = in_char;
                    last_next = in_last;
                end
                crx_pkg::OP_SET_CNT:
                begin
                    cnt_next = w0_reg;
                end
                crx_pkg::OP_RANGE_STEP:
                begin
                    cnt_next = cnt_reg + 8'd1;
                    if (status.run_done)
                    begin
                        fill_next = 2'd0;
                    end
                end
                crx_pkg::OP_SHIFT_IN:
                begin
                    w0_next   = w1_reg;
                    w1_next   = c_reg;
                    fill_next = 2'd2;
                end
                crx_pkg::OP_INSERT:
                begin
                    if (fill_reg == 2'd0)
                    begin
                        w0_next = c_reg;
                    end
                    else
                    begin
                        w1_next = c_reg;
                    end
                    fill_next = fill_reg + 2'd1;
                end
                crx_pkg::OP_SHIFT_OUT:
                begin
                    w0_next   = w1_reg;
                    fill_next = fill_reg - 2'd1;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    assign emit_beat = ctrl.fire && ctrl.emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;
        text_end_next  = text_end_reg;
        if (emit_beat)
        begin
            out_valid_next = 1'b1;
            out_char_next  = (ctrl.src == crx_pkg::SRC_CNT) ? cnt_reg : w0_reg;
            run_last_next  = ctrl.run_last;
            text_end_next  = ctrl.run_last && last_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        c_reg        <= c_next;
        last_reg     <= last_next;
        cnt_reg      <= cnt_next;
        out_char_reg <= out_char_next;
        run_last_reg <= run_last_next;
        text_end_reg <= text_end_next;
    end

    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;
    assign text_end  = text_end_reg;
    assign out_valid = out_valid_reg;

    `CRX_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg != 2'd3)
    `CRX_ASSERT_IMPL(a_end_is_run_last, out_valid_reg && text_end_reg, run_last_reg)
    `CRX_ASSERT_IMPL(a_range_in_bounds, emit_beat && (ctrl.src == crx_pkg::SRC_CNT),
                     cnt_reg <= c_reg)
    `CRX_ASSERT_NEXT(a_range_empties_window,
                     ctrl.fire && (ctrl.op == crx_pkg::OP_RANGE_STEP) && status.run_done,
                     fill_reg == 2'd0)

endmodule

FILE: rtl/character_range_expander_unit.sv
// Flow: a byte is taken only in the fetch step; the microprogram then tests the window and
// emits its beats (literal, range member or flushed byte) through the output register, and
// in_stall holds the next byte off until it is back at fetch. Each emitting step of the
// microprogram holds while the output register stalls; there is a single output register.
// Reset: rst_n clears the step counter, window fill count and output valid; window empty.
module character_range_expander_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       text_end,
    output logic       out_valid,
    input  logic       out_stall
);

    crx_pkg::ctrl_t   ctrl;
    crx_pkg::status_t status;

    crx_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    crx_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (in_char),
        .in_last   (in_last),
        .ctrl      (ctrl),
        .status    (status),
        .out_char  (out_char),
        .run_last  (run_last),
        .text_end  (text_end),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       text_end;
    } beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       typed_has;
        logic [7:0] typed_ch;
    } row_t;

    localparam string PASS_MSG = "character_range_expander_unit regression: pass";

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] in_char = 8'h00;
    logic       in_last = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] out_char;
    logic       run_last;
    logic       text_end;
    logic       out_valid;
    logic       out_stall = 1'b0;

    beat_t      expected_beats[$];
    beat_t      step_beats[$];
    logic [7:0] held_bytes[2];
    int         held_count;
    logic [7:0] text_bytes[$];

    int         fail_count;
    int         items_sent;
    int         beats_seen;
    int         texts_sent;
    int         ranges_sent;
    int         stall_left;
    logic       stall_quiet;

    row_t directed_rows [0:24] = '{
        '{8'h41, 1'b1, 1'b1, 1'b1, 8'h41},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF},
        '{8'h01, 1'b1, 1'b1, 1'b1, 8'h01},
        '{8'h61, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h2D, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h7A, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h41, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h2D, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h5A, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h30, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h2D, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h39, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h39, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h2D, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h30, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h2D, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h61, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h2D, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h61, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h2D, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h5A, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h62, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h2D, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h62, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00}
    };

    character_range_expander_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (in_char),
        .in_last   (in_last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_char  (out_char),
        .run_last  (run_last),
        .text_end  (text_end),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    always #1 clk = ~clk;

    function automatic crx_pkg::class_t char_class(logic [7:0] b);
        if (b >= crx_pkg::CH_UPPER_A && b <= crx_pkg::CH_UPPER_Z)
        begin
            return crx_pkg::CLASS_UPPER;
        end
        if (b >= crx_pkg::CH_LOWER_A && b <= crx_pkg::CH_LOWER_Z)
        begin
            return crx_pkg::CLASS_LOWER;
        end
        if (b >= crx_pkg::CH_DIGIT_0 && b <= crx_pkg::CH_DIGIT_9)
        begin
            return crx_pkg::CLASS_DIGIT;
        end
        return crx_pkg::CLASS_NONE;
    endfunction

    function automatic void push_step_beat(logic [7:0] b);
        beat_t bt;
        bt.ch       = b;
        bt.run_last = 1'b0;
        bt.text_end = 1'b0;
        step_beats.push_back(bt);
    endfunction

    // Advances the lookahead window by one byte and collects the beats it releases.
    function automatic void expand_byte(logic [7:0] c, logic last);
        crx_pkg::class_t cls;
        int              v;
        int              n;
        step_beats.delete();
        if (held_count == 2)
        begin
            cls = char_class(held_bytes[0]);
            if (cls != crx_pkg::CLASS_NONE && held_bytes[1] == crx_pkg::CH_DASH
                && char_class(c) == cls && c >= held_bytes[0])
            begin
                for (v = held_bytes[0]; v <= c; v++)
                begin
                    push_step_beat(v[7:0]);
                end
                held_count = 0;
            end
            else
            begin
                push_step_beat(held_bytes[0]);
                held_bytes[0] = held_bytes[1];
                held_bytes[1] = c;
            end
        end
        else
        begin
            held_bytes[held_count] = c;
            held_count++;
        end
        if (last)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                push_step_beat(held_bytes[i]);
            end
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            held_count = 0;
        end
        n = step_beats.size();
        if (n > 0)
        begin
            step_beats[n - 1].run_last = 1'b1;
            step_beats[n - 1].text_end = last;
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic l, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_char  <= c;
        in_last  <= l;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    function automatic void build_text();
        int         tokens;
        int         kind;
        int         span;
        int         lo;
        int         hi;
        int         t;
        logic [7:0] base;
        text_bytes.delete();
        tokens = $urandom_range(1, 5);
        for (int k = 0; k < tokens; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 4 || kind == 8)
            begin
                t = $urandom_range(0, 2);
                base = (t == 0) ? crx_pkg::CH_UPPER_A :
                       (t == 1) ? crx_pkg::CH_LOWER_A : crx_pkg::CH_DIGIT_0;
                span = (t == 2) ? 10 : 26;
                lo = $urandom_range(0, span - 1);
                if ($urandom_range(0, 7) == 0)
                begin
                    hi = $urandom_range(lo, span - 1);
                end
                else
                begin
                    hi = lo + $urandom_range(0, (span - 1 - lo < 4) ? span - 1 - lo : 4);
                end
                if (kind == 8)
                begin
                    text_bytes.push_back(base + lo[7:0]);
                end
                else
                begin
                    if ($urandom_range(0, 6) == 0 && lo != hi)
                    begin
                        t = lo;
                        lo = hi;
                        hi = t;
                    end
                    text_bytes.push_back(base + lo[7:0]);
                    text_bytes.push_back(crx_pkg::CH_DASH);
                    text_bytes.push_back(base + hi[7:0]);
                    ranges_sent++;
                end
            end
            else if (kind <= 6)
            begin
                text_bytes.push_back(8'($urandom_range(1, 255)));
            end
            else if (kind == 7)
            begin
                text_bytes.push_back(crx_pkg::CH_DASH);
            end
            else
            begin
                text_bytes.push_back(crx_pkg::CH_DASH);
                text_bytes.push_back(crx_pkg::CH_DASH);
            end
        end
    endfunction

    // Output side: checks each accepted beat and draws a fresh stall length after it.
    always @(posedge clk)
    begin
        beat_t want;
        int    n;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen++;
            if (beats_seen % 50 == 0)
            begin
                stall_quiet = ($urandom_range(0, 2) == 0);
            end
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: out_char %h", out_char);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_char !== want.ch)
                begin
                    $error("out_char mismatch: expected %h, got %h", want.ch, out_char);
                    fail_count++;
                end
                if (run_last !== want.run_last)
                begin
                    $error("run_last mismatch: expected %b, got %b", want.run_last, run_last);
                    fail_count++;
                end
                if (text_end !== want.text_end)
                begin
                    $error("text_end mismatch: expected %b, got %b", want.text_end, text_end);
                    fail_count++;
                end
            end
            n = stall_quiet ? 0 : $urandom_range(0, 16);
            out_stall  <= (n > 0);
            stall_left <= n;
        end
        else if (out_stall)
        begin
            if (stall_left <= 1)
            begin
                out_stall <= 1'b0;
            end
            stall_left <= stall_left - 1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("character_range_expander_unit regression: fail");
        $finish;
    end

    initial
    begin
        row_t row;
        logic quiet_send;
        logic paused;
        int   gap;
        fail_count  = 0;
        items_sent  = 0;
        beats_seen  = 0;
        texts_sent  = 0;
        ranges_sent = 0;
        stall_left  = 0;
        stall_quiet = 1'b0;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_count  = 0;
        paused      = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < 25; r++)
        begin
            row = directed_rows[r];
            gap = $urandom_range(0, 16);
            send_byte(row.ch, row.last, gap);
            expand_byte(row.ch, row.last);
            if (row.typed)
            begin
                if (row.typed_has)
                begin
                    expected_beats.push_back('{row.typed_ch, 1'b1, row.last});
                end
            end
            else
            begin
                foreach (step_beats[i])
                begin
                    expected_beats.push_back(step_beats[i]);
                end
            end
            if (row.last)
            begin
                texts_sent++;
            end
        end

        while (items_sent < 450)
        begin
            if (!paused && items_sent >= 250)
            begin
                // Hold the input off until the output side has drained every beat.
                paused = 1'b1;
                in_valid <= 1'b0;
                while (expected_beats.size() != 0) @(posedge clk);
                repeat (8) @(posedge clk);
            end
            build_text();
            quiet_send = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < text_bytes.size(); i++)
            begin
                gap = quiet_send ? 0 : $urandom_range(0, 16);
                send_byte(text_bytes[i], i == text_bytes.size() - 1, gap);
                expand_byte(text_bytes[i], i == text_bytes.size() - 1);
                foreach (step_beats[j])
                begin
                    expected_beats.push_back(step_beats[j]);
                end
            end
            texts_sent++;
        end

        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_beats.size());
            fail_count++;
        end

        $display("Sent %0d bytes in %0d texts, with %0d range tokens among them.",
                 items_sent, texts_sent, ranges_sent);
        $display("Checked %0d output beats under random gaps and stalls.", beats_seen);
        if (fail_count == 0)
        begin
            $display(PASS_MSG);
        end
        else
        begin
            $display("character_range_expander_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: character_range_expander_unit.f
+incdir+rtl
rtl/crx_pkg.sv
rtl/crx_sequencer.sv
rtl/crx_datapath.sv
rtl/character_range_expander_unit.sv
sim/testbench.sv
